// ===== rtl/htp_pkg.sv =====
// shared types, codes and defaults for the hierarchical state machine transition path
// no dependencies
`default_nettype none

package htp_pkg;

   localparam int NUM_STATES_DEF = 16;
   localparam int MAX_DEPTH_DEF  = 8;

   localparam int ID_W  = 4;
   localparam int LVL_W = 3;

   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_INITIAL = 2'd1;
   localparam logic [1:0] MODE_CHANGE  = 2'd2;

   localparam logic ACT_EXIT  = 1'b0;
   localparam logic ACT_ENTER = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  parent;
      logic             root;
      logic [LVL_W-1:0] level;
   } htp_entry_type;

   localparam int ENTRY_W = $bits(htp_entry_type);

   typedef struct packed {
      logic            valid;
      logic            action;
      logic [ID_W-1:0] target;
      logic            error;
      logic            last;
   } htp_beat_type;

endpackage

`default_nettype wire

// ===== rtl/htp_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module htp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/htp_seq.sv =====
// transition sequencer: table writes, ancestor walk over the table rams, exit and entry stacks
// depends on htp_pkg
`default_nettype none

module htp_seq #(
   parameter int NUM_STATES = htp_pkg::NUM_STATES_DEF,
   parameter int MAX_DEPTH  = htp_pkg::MAX_DEPTH_DEF,
   localparam int AW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [htp_pkg::ID_W-1:0]    req_state_id,
   input  wire logic [htp_pkg::ID_W-1:0]    req_parent_id,
   input  wire logic                        req_has_parent,
   input  wire logic [htp_pkg::LVL_W-1:0]   req_nest_level,
   output logic                             tbl_wr_en,
   output logic [AW-1:0]                    tbl_wr_addr,
   output htp_pkg::htp_entry_type           tbl_wr_data,
   output logic [AW-1:0]                    f_addr,
   output logic [AW-1:0]                    t_addr,
   input  wire htp_pkg::htp_entry_type      f_entry,
   input  wire htp_pkg::htp_entry_type      t_entry,
   output htp_pkg::htp_beat_type            beat,
   input  wire logic                        beat_ready
);

   localparam int CW = $clog2(MAX_DEPTH + 1);
   localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(MAX_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [8:0]    NS_C    = 9'(NUM_STATES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_EXIT  = 3'd2;
   localparam logic [2:0] ST_ENTER = 3'd3;
   localparam logic [2:0] ST_ONE   = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [htp_pkg::ID_W-1:0]   cur_ff, cur_in;
   logic [htp_pkg::ID_W-1:0]   sid_ff, sid_in;
   logic [htp_pkg::ID_W-1:0]   f_ff, f_in;
   logic [htp_pkg::ID_W-1:0]   t_ff, t_in;
   logic                       f_rng_ff, f_rng_in;
   logic                       t_rng_ff, t_rng_in;
   logic                       eq_ff, eq_in;
   logic [CW-1:0]              nx_ff, nx_in;
   logic [CW-1:0]              ne_ff, ne_in;
   logic [CW-1:0]              xi_ff, xi_in;
   logic                       one_act_ff, one_act_in;
   logic                       one_err_ff, one_err_in;
   logic [htp_pkg::ID_W-1:0]   exit_stk_ff [MAX_DEPTH];
   logic [htp_pkg::ID_W-1:0]   ent_stk_ff  [MAX_DEPTH];

   logic                       accept;
   logic                       x_push, e_push;
   logic                       done, fault;
   logic [htp_pkg::LVL_W-1:0]  lf, lt;
   logic                       rf, rt;
   logic [htp_pkg::ID_W-1:0]   pf, pt;
   logic [CW-1:0]              ne_m1, nx_m1, nx_next;

   assign lf = f_rng_ff ? f_entry.level  : '0;
   assign lt = t_rng_ff ? t_entry.level  : '0;
   assign rf = f_rng_ff ? f_entry.root   : 1'b1;
   assign rt = t_rng_ff ? t_entry.root   : 1'b1;
   assign pf = f_rng_ff ? f_entry.parent : '0;
   assign pt = t_rng_ff ? t_entry.parent : '0;

   assign ne_m1 = ne_ff - ONE_C;
   assign nx_m1 = nx_ff - ONE_C;

   assign accept = req_valid && req_ready;

   assign tbl_wr_addr        = AW'(req_state_id);
   assign tbl_wr_data.parent = req_parent_id;
   assign tbl_wr_data.root   = !req_has_parent;
   assign tbl_wr_data.level  = req_nest_level;
   assign f_addr             = AW'(f_in);
   assign t_addr             = AW'(t_in);
   assign f_rng_in           = ({5'd0, f_in} < NS_C);
   assign t_rng_in           = ({5'd0, t_in} < NS_C);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      sid_in     = sid_ff;
      f_in       = f_ff;
      t_in       = t_ff;
      eq_in      = eq_ff;
      nx_in      = nx_ff;
      ne_in      = ne_ff;
      xi_in      = xi_ff;
      one_act_in = one_act_ff;
      one_err_in = one_err_ff;
      req_ready  = 1'b0;
      tbl_wr_en  = 1'b0;
      x_push     = 1'b0;
      e_push     = 1'b0;
      done       = 1'b0;
      fault      = 1'b0;
      nx_next    = nx_ff;
      beat       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               priority if (req_mode == htp_pkg::MODE_WRITE) begin
                  tbl_wr_en = ({5'd0, req_state_id} < NS_C);
               end else if (req_mode == htp_pkg::MODE_INITIAL) begin
                  cur_in     = req_state_id;
                  sid_in     = req_state_id;
                  one_act_in = htp_pkg::ACT_ENTER;
                  one_err_in = 1'b0;
                  state_in   = ST_ONE;
               end else if (req_mode == htp_pkg::MODE_CHANGE && req_state_id != cur_ff) begin
                  f_in     = cur_ff;
                  t_in     = req_state_id;
                  sid_in   = req_state_id;
                  eq_in    = 1'b0;
                  nx_in    = '0;
                  ne_in    = '0;
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            if (!eq_ff && lf != lt) begin
               if (lf > lt) begin
                  if (nx_ff == DEPTH_C || rf) begin
                     fault = 1'b1;
                  end else begin
                     x_push = 1'b1;
                     nx_in  = nx_ff + ONE_C;
                     f_in   = pf;
                  end
               end else begin
                  if (ne_ff == DEPTH_C || rt) begin
                     fault = 1'b1;
                  end else begin
                     e_push = 1'b1;
                     ne_in  = ne_ff + ONE_C;
                     t_in   = pt;
                  end
               end
            end else begin
               eq_in = 1'b1;
               priority if (f_ff == t_ff) begin
                  done = 1'b1;
               end else if (nx_ff == DEPTH_C || ne_ff == DEPTH_C) begin
                  fault = 1'b1;
               end else begin
                  x_push = 1'b1;
                  e_push = 1'b1;
                  nx_in  = nx_ff + ONE_C;
                  ne_in  = ne_ff + ONE_C;
                  priority if (rf && rt) begin
                     done = 1'b1;
                  end else if (rf || rt) begin
                     fault = 1'b1;
                  end else begin
                     f_in = pf;
                     t_in = pt;
                  end
               end
            end
            nx_next = nx_in;
            priority if (fault) begin
               one_act_in = htp_pkg::ACT_EXIT;
               one_err_in = 1'b1;
               state_in   = ST_ONE;
            end else if (done) begin
               cur_in   = sid_ff;
               xi_in    = '0;
               state_in = (nx_next != '0) ? ST_EXIT : ST_ENTER;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_EXIT: begin
            beat.valid  = 1'b1;
            beat.action = htp_pkg::ACT_EXIT;
            beat.target = exit_stk_ff[xi_ff[SW-1:0]];
            beat.last   = (xi_ff == nx_m1) && (ne_ff == '0);
            if (beat_ready) begin
               xi_in = xi_ff + ONE_C;
               if (xi_ff == nx_m1) begin
                  state_in = (ne_ff != '0) ? ST_ENTER : ST_IDLE;
               end
            end
         end
         ST_ENTER: begin
            beat.valid  = 1'b1;
            beat.action = htp_pkg::ACT_ENTER;
            beat.target = ent_stk_ff[ne_m1[SW-1:0]];
            beat.last   = (ne_ff == ONE_C);
            if (beat_ready) begin
               ne_in = ne_m1;
               if (ne_ff == ONE_C) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ONE: begin
            beat.valid  = 1'b1;
            beat.action = one_act_ff;
            beat.target = sid_ff;
            beat.error  = one_err_ff;
            beat.last   = 1'b1;
            if (beat_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
         eq_ff    <= 1'b0;
         nx_ff    <= '0;
         ne_ff    <= '0;
         xi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         eq_ff    <= eq_in;
         nx_ff    <= nx_in;
         ne_ff    <= ne_in;
         xi_ff    <= xi_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff     <= sid_in;
      f_ff       <= f_in;
      t_ff       <= t_in;
      f_rng_ff   <= f_rng_in;
      t_rng_ff   <= t_rng_in;
      one_act_ff <= one_act_in;
      one_err_ff <= one_err_in;
      if (x_push) begin
         exit_stk_ff[nx_ff[SW-1:0]] <= f_ff;
      end
      if (e_push) begin
         ent_stk_ff[ne_ff[SW-1:0]] <= t_ff;
      end
   end

`ifndef SYNTH
   a_change_starts_walk: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == htp_pkg::MODE_CHANGE && req_state_id != cur_ff
      |=> state_ff == ST_WALK)
      else $error("change beat did not start the walk");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      nx_ff <= DEPTH_C && ne_ff <= DEPTH_C)
      else $error("stack count beyond depth bound");

   a_enter_has_entries: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ENTER |-> ne_ff != '0)
      else $error("entry emission with empty stack");

   a_exit_index_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXIT |-> xi_ff < nx_ff)
      else $error("exit index past exit count");
`endif

endmodule

`default_nettype wire

// ===== rtl/htp_out.sv =====
// output register for result beats, decouples the sequencer from the rsp channel
// depends on htp_pkg
`default_nettype none

module htp_out (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire htp_pkg::htp_beat_type     beat,
   output logic                           beat_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_action,
   output logic [htp_pkg::ID_W-1:0]       rsp_target,
   output logic                           rsp_error,
   output logic                           rsp_last
);

   logic                     valid_ff, valid_in;
   logic                     action_ff;
   logic [htp_pkg::ID_W-1:0] target_ff;
   logic                     error_ff;
   logic                     last_ff;
   logic                     load;

   assign beat_ready = !valid_ff || rsp_ready;
   assign load       = beat.valid && beat_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= beat.action;
         target_ff <= beat.target;
         error_ff  <= beat.error;
         last_ff   <= beat.last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_action = action_ff;
   assign rsp_target = target_ff;
   assign rsp_error  = error_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

// ===== rtl/hsm_transition_path.sv =====
// hierarchical state machine transition path: top level with two table ram copies
// depends on htp_pkg, htp_ram, htp_seq, htp_out
// a write beat writes both table copies when accepted; an initial beat yields a single enter beat
// a change walks one ancestor step per cycle, then moves one result beat per cycle to the
// output register whenever that register can take it (beat_ready)
// reset clears control state and the current state; table contents are undefined until written
`default_nettype none

module hsm_transition_path #(
   parameter int NUM_STATES = htp_pkg::NUM_STATES_DEF,
   parameter int MAX_DEPTH  = htp_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [htp_pkg::ID_W-1:0]    req_state_id,
   input  wire logic [htp_pkg::ID_W-1:0]    req_parent_id,
   input  wire logic                        req_has_parent,
   input  wire logic [htp_pkg::LVL_W-1:0]   req_nest_level,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_action,
   output logic [htp_pkg::ID_W-1:0]         rsp_target,
   output logic                             rsp_error,
   output logic                             rsp_last
);

   localparam int AW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

   logic                   tbl_wr_en;
   logic [AW-1:0]          tbl_wr_addr;
   htp_pkg::htp_entry_type tbl_wr_data;
   logic [AW-1:0]          f_addr, t_addr;
   htp_pkg::htp_entry_type f_entry, t_entry;
   htp_pkg::htp_beat_type  beat;
   logic                   beat_ready;

   htp_ram #(
      .WIDTH (htp_pkg::ENTRY_W),
      .DEPTH (NUM_STATES)
   ) u_ram_f (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (f_addr),
      .rd_data (f_entry)
   );

   htp_ram #(
      .WIDTH (htp_pkg::ENTRY_W),
      .DEPTH (NUM_STATES)
   ) u_ram_t (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (t_addr),
      .rd_data (t_entry)
   );

   htp_seq #(
      .NUM_STATES (NUM_STATES),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_state_id   (req_state_id),
      .req_parent_id  (req_parent_id),
      .req_has_parent (req_has_parent),
      .req_nest_level (req_nest_level),
      .tbl_wr_en      (tbl_wr_en),
      .tbl_wr_addr    (tbl_wr_addr),
      .tbl_wr_data    (tbl_wr_data),
      .f_addr         (f_addr),
      .t_addr         (t_addr),
      .f_entry        (f_entry),
      .t_entry        (t_entry),
      .beat           (beat),
      .beat_ready     (beat_ready)
   );

   htp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .beat_ready (beat_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_action (rsp_action),
      .rsp_target (rsp_target),
      .rsp_error  (rsp_error),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the hierarchical state machine transition path block
// predicts exit and entry beats from its own copy of the state table and checks each result beat
// depends on htp_pkg and hsm_transition_path
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ID_W  = htp_pkg::ID_W;
   localparam int LVL_W = htp_pkg::LVL_W;
   localparam int NS    = htp_pkg::NUM_STATES_DEF;
   localparam int MD    = htp_pkg::MAX_DEPTH_DEF;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   class htp_scoreboard;
      typedef struct packed {
         logic            action;
         logic [ID_W-1:0] target;
         logic            error;
         logic            last;
      } path_beat_t;

      logic [ID_W-1:0]  parent_of   [NS];
      bit               root_of     [NS];
      logic [LVL_W-1:0] level_of    [NS];
      logic [ID_W-1:0]  entry_stack [MD];
      logic [ID_W-1:0]  entry_count;
      logic [ID_W-1:0]  cur_state;
      path_beat_t       path_q [$];
      int               fail_count;

      function new();
         cur_state   = '0;
         entry_count = '0;
         fail_count  = 0;
      endfunction

      function int pending();
         return path_q.size();
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void push_beat(logic act, logic [ID_W-1:0] tgt, logic err, logic lst);
         path_beat_t b;
         b.action = act;
         b.target = tgt;
         b.error  = err;
         b.last   = lst;
         path_q.push_back(b);
      endfunction

      function void note_request(logic [1:0] mode, logic [ID_W-1:0] sid,
                                 logic [ID_W-1:0] pid, logic hp, logic [LVL_W-1:0] lvl);
         logic [ID_W-1:0] exits [MD];
         logic [ID_W-1:0] ents  [MD];
         logic [ID_W-1:0] f, t;
         int nx, ne, k;
         bit fault, rf, rt;
         nx    = 0;
         ne    = 0;
         fault = 1'b0;
         case (mode)
            htp_pkg::MODE_WRITE: begin
               parent_of[sid] = pid;
               root_of[sid]   = !hp;
               level_of[sid]  = lvl;
            end
            htp_pkg::MODE_INITIAL: begin
               cur_state = sid;
               push_beat(htp_pkg::ACT_ENTER, sid, 1'b0, 1'b1);
            end
            htp_pkg::MODE_CHANGE: begin
               if (sid != cur_state) begin
                  f = cur_state;
                  t = sid;
                  // climb the deeper side until both sides sit at one level
                  while (!fault && level_of[f] != level_of[t]) begin
                     if (level_of[f] > level_of[t]) begin
                        if (nx >= MD || root_of[f]) begin
                           fault = 1'b1;
                        end else begin
                           exits[nx] = f;
                           nx++;
                           f = parent_of[f];
                        end
                     end else begin
                        if (ne >= MD || root_of[t]) begin
                           fault = 1'b1;
                        end else begin
                           ents[ne] = t;
                           ne++;
                           t = parent_of[t];
                        end
                     end
                  end
                  // climb both sides together up to the common ancestor
                  while (!fault && f != t) begin
                     if (nx >= MD || ne >= MD) begin
                        fault = 1'b1;
                     end else begin
                        exits[nx] = f;
                        nx++;
                        ents[ne] = t;
                        ne++;
                        rf = root_of[f];
                        rt = root_of[t];
                        if (rf && rt) break;
                        if (rf || rt) begin
                           fault = 1'b1;
                        end else begin
                           f = parent_of[f];
                           t = parent_of[t];
                        end
                     end
                  end
                  if (fault) begin
                     entry_count = '0;
                     push_beat(htp_pkg::ACT_EXIT, sid, 1'b1, 1'b1);
                  end else begin
                     for (k = 0; k < ne; k++) entry_stack[k] = ents[k];
                     entry_count = ID_W'(ne);
                     for (k = 0; k < nx; k++) begin
                        push_beat(htp_pkg::ACT_EXIT, exits[k], 1'b0,
                                  (k == nx - 1) && (ne == 0));
                     end
                     for (k = ne - 1; k >= 0; k--) begin
                        push_beat(htp_pkg::ACT_ENTER, ents[k], 1'b0, k == 0);
                     end
                     cur_state = sid;
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(logic act, logic [ID_W-1:0] tgt, logic err, logic lst);
         path_beat_t exp;
         if (path_q.size() == 0) begin
            report($sformatf("mismatch: unexpected beat action %0d target %0d error %0d last %0d",
                             act, tgt, err, lst));
            return;
         end
         exp = path_q.pop_front();
         if (exp.action !== act || exp.target !== tgt || exp.error !== err || exp.last !== lst)
         begin
            report($sformatf({"mismatch: expected action %0d target %0d error %0d last %0d,",
                              " got action %0d target %0d error %0d last %0d"},
                             exp.action, exp.target, exp.error, exp.last, act, tgt, err, lst));
         end
      endfunction
   endclass

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode       = htp_pkg::MODE_WRITE;
   logic [ID_W-1:0]   req_state_id   = '0;
   logic [ID_W-1:0]   req_parent_id  = '0;
   logic              req_has_parent = 1'b0;
   logic [LVL_W-1:0]  req_nest_level = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic              rsp_action;
   logic [ID_W-1:0]   rsp_target;
   logic              rsp_error;
   logic              rsp_last;

   int                send_idle_pct  = 0;
   int                rsp_stall_pct  = 0;
   htp_scoreboard     sb;

   hsm_transition_path u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_state_id   (req_state_id),
      .req_parent_id  (req_parent_id),
      .req_has_parent (req_has_parent),
      .req_nest_level (req_nest_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_action     (rsp_action),
      .rsp_target     (rsp_target),
      .rsp_error      (rsp_error),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_action, rsp_target, rsp_error, rsp_last);
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [ID_W-1:0] sid, pid,
                            input logic hp, input logic [LVL_W-1:0] lvl);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_state_id   <= sid;
      req_parent_id  <= pid;
      req_has_parent <= hp;
      req_nest_level <= lvl;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(mode, sid, pid, hp, lvl);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // random forest: every entry written, child level one below its parent
   task automatic build_tree();
      int perm [NS];
      int lv   [NS];
      int k, j, tmp, p;
      for (k = 0; k < NS; k++) perm[k] = k;
      for (k = NS - 1; k > 0; k--) begin
         j       = $urandom_range(k);
         tmp     = perm[k];
         perm[k] = perm[j];
         perm[j] = tmp;
      end
      for (k = 0; k < NS; k++) begin
         p = -1;
         if (k > 0 && $urandom_range(4) != 0) begin
            p = ($urandom_range(1) == 1) ? perm[k-1] : perm[$urandom_range(k - 1)];
            if (lv[p] == 7) p = -1;
         end
         if (p < 0) begin
            lv[perm[k]] = 0;
            send_item(htp_pkg::MODE_WRITE, ID_W'(perm[k]), ID_W'($urandom_range(15)), 1'b0,
                      3'd0);
         end else begin
            lv[perm[k]] = lv[p] + 1;
            send_item(htp_pkg::MODE_WRITE, ID_W'(perm[k]), ID_W'(p), 1'b1,
                      LVL_W'(lv[p] + 1));
         end
      end
   endtask

   task automatic run_round(input int n_moves);
      int r, tgt;
      build_tree();
      repeat (n_moves) begin
         r   = $urandom_range(99);
         tgt = $urandom_range(15);
         if (r < 68) begin
            send_item(htp_pkg::MODE_CHANGE, ID_W'(tgt), ID_W'($urandom_range(15)),
                      1'($urandom_range(1)), LVL_W'($urandom_range(7)));
         end else if (r < 78) begin
            send_item(htp_pkg::MODE_INITIAL, ID_W'(tgt), ID_W'($urandom_range(15)),
                      1'($urandom_range(1)), LVL_W'($urandom_range(7)));
         end else if (r < 84) begin
            send_item(htp_pkg::MODE_CHANGE, sb.cur_state, ID_W'($urandom_range(15)),
                      1'($urandom_range(1)), LVL_W'($urandom_range(7)));
         end else if (r < 88) begin
            send_item(MODE_UNUSED, ID_W'(tgt), ID_W'($urandom_range(15)),
                      1'($urandom_range(1)), LVL_W'($urandom_range(7)));
         end else begin
            // corrupting write, may leave the table inconsistent
            send_item(htp_pkg::MODE_WRITE, ID_W'(tgt), ID_W'($urandom_range(15)),
                      1'($urandom_range(1)), LVL_W'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      int ph, i;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // two chains of depth eight: 0..7 and 8..15, each with a root at level 0
      for (i = 0; i < NS; i++) begin
         send_item(htp_pkg::MODE_WRITE, ID_W'(i), ID_W'((i % 8 == 0) ? i : i - 1),
                   (i % 8) != 0, LVL_W'(i % 8));
      end
      send_item(htp_pkg::MODE_INITIAL, 4'd7, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_CHANGE, 4'd15, 4'd15, 1'b1, 3'd7);
      send_item(htp_pkg::MODE_CHANGE, 4'd15, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_CHANGE, 4'd8, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_CHANGE, 4'd11, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_CHANGE, 4'd3, 4'd0, 1'b0, 3'd0);
      send_item(MODE_UNUSED, 4'd15, 4'd15, 1'b1, 3'd7);
      // root in the middle of a chain: walk has to step above a root
      send_item(htp_pkg::MODE_WRITE, 4'd5, 4'd4, 1'b0, 3'd5);
      send_item(htp_pkg::MODE_CHANGE, 4'd6, 4'd0, 1'b0, 3'd0);
      // self loops at one level: walk runs past the depth bound
      send_item(htp_pkg::MODE_WRITE, 4'd12, 4'd12, 1'b1, 3'd4);
      send_item(htp_pkg::MODE_WRITE, 4'd13, 4'd13, 1'b1, 3'd4);
      send_item(htp_pkg::MODE_INITIAL, 4'd13, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_CHANGE, 4'd12, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_WRITE, 4'd14, 4'd14, 1'b1, 3'd7);
      send_item(htp_pkg::MODE_INITIAL, 4'd14, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_CHANGE, 4'd0, 4'd0, 1'b0, 3'd0);
      send_item(htp_pkg::MODE_INITIAL, 4'd0, 4'd15, 1'b1, 3'd7);
      send_item(htp_pkg::MODE_INITIAL, 4'd15, 4'd0, 1'b0, 3'd0);
      drain_results();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 71;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 71;
            end
            default: begin
               send_idle_pct = 37;
               rsp_stall_pct = 37;
            end
         endcase
         repeat (2) run_round(19);
         drain_results();
      end

      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
